FILE: rtl/lns_pkg.sv
// ----------------------------------------------------------------------------
// lns_pkg
// Shared types, codes and constants of the LWE noise sampler.
// ----------------------------------------------------------------------------
package lns_pkg;

   // sample kinds, one per component
   typedef enum logic [1:0] {
      KIND_ETA1  = 2'd0,
      KIND_ETA3  = 2'd1,
      KIND_GAUSS = 2'd2,
      KIND_UNIF  = 2'd3
   } kind_type;

   // component codes
   localparam logic [1:0] COMP_R  = 2'd0;
   localparam logic [1:0] COMP_E1 = 2'd1;
   localparam logic [1:0] COMP_E2 = 2'd2;

   // register indexes (word address)
   localparam logic [2:0] REG_R_KIND     = 3'd0;
   localparam logic [2:0] REG_E1_KIND    = 3'd1;
   localparam logic [2:0] REG_E2_KIND    = 3'd2;
   localparam logic [2:0] REG_SIGMA      = 3'd3;
   localparam logic [2:0] REG_VECTOR_LEN = 3'd4;

   localparam int SIGMA_W     = 11;
   localparam int LEN_W       = 11;
   localparam int DEF_MAX_LEN = 1024;

   // inverse CDF table: 128 magnitudes in Q12
   localparam int TBL_DEPTH = 128;
   localparam int TBL_AW    = 7;
   localparam int ZW        = 15;

   // generator constants
   localparam logic [30:0] PHI0_Q32 = 31'd1713444047;
   localparam int          AREA_W   = 46;

   // reset values
   localparam kind_type             RST_R_KIND  = KIND_GAUSS;
   localparam kind_type             RST_E1_KIND = KIND_GAUSS;
   localparam kind_type             RST_E2_KIND = KIND_UNIF;
   localparam logic [SIGMA_W-1:0]   RST_SIGMA   = 11'd589;
   localparam logic [LEN_W-1:0]     RST_LEN     = 11'd512;

   typedef enum logic [3:0] {
      GEN_START,
      GEN_TOP,
      GEN_MUL1,
      GEN_MUL2,
      GEN_MUL3,
      GEN_DIV,
      GEN_ADD,
      GEN_CHK,
      GEN_FILL,
      GEN_DONE
   } gen_state_type;

   typedef struct packed {
      kind_type             r_kind;
      kind_type             e1_kind;
      kind_type             e2_kind;
      logic [SIGMA_W-1:0]   sigma;
      logic [LEN_W-1:0]     vector_len;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [TBL_AW-1:0] addr;
      logic [ZW-1:0]     data;
   } tbl_wr_type;

   // byte mod 7 through a reciprocal multiply (exact for 8-bit inputs)
   function automatic logic [2:0] mod7(input logic [7:0] b);
      logic [18:0] p;
      logic [10:0] r;
      p = 19'(b) * 19'd293;
      r = 11'(b) - 11'(p[18:11]) * 11'd7;
      return r[2:0];
   endfunction

endpackage

FILE: rtl/lns_table_gen.sv
// ----------------------------------------------------------------------------
// lns_table_gen
// Builds the inverse normal CDF table after reset by integrating the normal
// density on a 1/4096 grid; one shared multiplier serves every grid step.
// ----------------------------------------------------------------------------
module lns_table_gen (
   input  logic                clock,
   input  logic                reset,
   output lns_pkg::tbl_wr_type tbl_wr,
   output logic                done
);
   import lns_pkg::*;

   gen_state_type state_ff, state_in;

   logic [14:0]       i_ff;
   logic [7:0]        k_ff;
   logic [30:0]       dens_ff;
   logic [AREA_W-1:0] area_ff;
   logic [21:0]       t1_ff, t2_ff, t3_ff;
   logic [19:0]       q6_ff;
   logic [30:0]       nxt_ff;
   logic [AREA_W-1:0] anext_ff;

   logic [21:0]       d;
   logic [30:0]       mul_a;
   logic [52:0]       prod;
   logic [53:0]       prod_rnd;
   logic [21:0]       mres;
   logic [37:0]       div_p;
   logic [31:0]       nxt_w;
   logic [AREA_W-1:0] target;
   logic              hit;
   logic [ZW-1:0]     pick;

   // grid point offset d = 256*i + 128
   assign d = {i_ff[13:0], 8'h80};

   // shared multiplier with Q32 rounding
   always_comb begin
      case (state_ff)
         GEN_MUL2: mul_a = {9'b0, t1_ff};
         GEN_MUL3: mul_a = {9'b0, t2_ff};
         default:  mul_a = dens_ff;
      endcase
   end
   assign prod     = 53'(mul_a) * 53'(d);
   assign prod_rnd = {1'b0, prod} + 54'h0_8000_0000;
   assign mres     = prod_rnd[53:32];

   // t3 / 6 by reciprocal
   assign div_p = 38'(t3_ff) * 38'd43691;

   assign nxt_w = 32'(dens_ff) - 32'(t1_ff) + 32'(t2_ff[21:1]) - 32'(q6_ff);

   // area target for entry k: (2k+1) << 36
   assign target = {2'b00, k_ff[6:0], 1'b1, 36'b0};
   assign hit    = !k_ff[7] && (anext_ff >= target);
   assign pick   = ((target - area_ff) <= (anext_ff - target)) ? i_ff : i_ff + 15'd1;

   // next state and table writes
   always_comb begin
      state_in     = state_ff;
      tbl_wr.we    = 1'b0;
      tbl_wr.addr  = k_ff[6:0];
      tbl_wr.data  = pick;
      case (state_ff)
         GEN_START: state_in = GEN_TOP;
         GEN_TOP: begin
            if (k_ff[7])      state_in = GEN_DONE;
            else if (i_ff[14]) state_in = GEN_FILL;
            else              state_in = GEN_MUL1;
         end
         GEN_MUL1: state_in = GEN_MUL2;
         GEN_MUL2: state_in = GEN_MUL3;
         GEN_MUL3: state_in = GEN_DIV;
         GEN_DIV:  state_in = GEN_ADD;
         GEN_ADD:  state_in = GEN_CHK;
         GEN_CHK: begin
            if (hit) begin
               tbl_wr.we = 1'b1;
            end else begin
               state_in = GEN_TOP;
            end
         end
         GEN_FILL: begin
            tbl_wr.we   = 1'b1;
            tbl_wr.data = i_ff;
            if (k_ff[6:0] == 7'h7F) state_in = GEN_DONE;
         end
         GEN_DONE: state_in = GEN_DONE;
         default:  state_in = GEN_START;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= GEN_START;
      else       state_ff <= state_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff    <= '0;
         k_ff    <= '0;
         dens_ff <= PHI0_Q32;
         area_ff <= '0;
      end else begin
         case (state_ff)
            GEN_MUL1: t1_ff <= mres;
            GEN_MUL2: t2_ff <= mres;
            GEN_MUL3: t3_ff <= mres;
            GEN_DIV:  q6_ff <= div_p[37:18];
            GEN_ADD: begin
               nxt_ff   <= nxt_w[30:0];
               anext_ff <= area_ff + AREA_W'(dens_ff) + AREA_W'(nxt_w[30:0]);
            end
            GEN_CHK: begin
               if (hit) begin
                  k_ff <= k_ff + 8'd1;
               end else begin
                  area_ff <= anext_ff;
                  dens_ff <= nxt_ff;
                  i_ff    <= i_ff + 15'd1;
               end
            end
            GEN_FILL: k_ff <= k_ff + 8'd1;
            default: ;
         endcase
      end
   end

   assign done = (state_ff == GEN_DONE);

endmodule

FILE: rtl/lns_sample_pipe.sv
// ----------------------------------------------------------------------------
// lns_sample_pipe
// Three-stage sample pipeline: position and table read, multiply by sigma,
// clamp and round into the output register.
// ----------------------------------------------------------------------------
module lns_sample_pipe #(
   parameter int MAX_LEN = lns_pkg::DEF_MAX_LEN
) (
   input  logic                clock,
   input  logic                reset,
   input  lns_pkg::cfg_type    cfg,
   input  lns_pkg::tbl_wr_type tbl_wr,
   input  logic                tbl_ready,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_random_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [6:0]   rsp_sample,
   output logic [1:0]          rsp_component,
   output logic                rsp_last
);
   import lns_pkg::*;

   localparam int PW = $clog2(2 * MAX_LEN + 1);

   logic [ZW-1:0] tbl_mem [TBL_DEPTH];

   logic          adv, accept;
   logic [PW-1:0] pos_ff, pos_in, len_eff;
   logic [1:0]    comp_in;
   logic          last_in;
   kind_type      kind;
   logic [7:0]    b;
   logic [6:0]    small_in;
   logic [TBL_AW-1:0] rd_addr;

   logic          v1_ff, gauss1_ff, neg1_ff, last1_ff;
   logic [6:0]    small1_ff;
   logic [1:0]    comp1_ff;
   logic [ZW-1:0] rd_ff;

   logic          v2_ff, gauss2_ff, neg2_ff, last2_ff;
   logic [6:0]    small2_ff;
   logic [1:0]    comp2_ff;
   logic [25:0]   prod2_ff;

   logic [25:0]   bound, clamped;
   logic [26:0]   rnd;
   logic [6:0]    gmag, sample_in;

   logic          rsp_valid_ff, rsp_last_ff;
   logic [6:0]    rsp_sample_ff;
   logic [1:0]    rsp_comp_ff;

   // whole pipeline moves unless the output holds a stalled transaction
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !tbl_ready || !adv;
   assign accept    = req_valid && !req_stall;
   assign b         = req_random_byte;

   // effective length, clamped to 1..MAX_LEN
   always_comb begin
      if (cfg.vector_len == '0)
         len_eff = PW'(1);
      else if (32'(cfg.vector_len) > 32'(MAX_LEN))
         len_eff = PW'(MAX_LEN);
      else
         len_eff = PW'(cfg.vector_len);
   end

   // component select and position step
   always_comb begin
      last_in = 1'b0;
      if (pos_ff < len_eff) begin
         comp_in = COMP_R;
         kind    = cfg.r_kind;
         pos_in  = pos_ff + PW'(1);
      end else if (pos_ff < (len_eff << 1)) begin
         comp_in = COMP_E1;
         kind    = cfg.e1_kind;
         pos_in  = pos_ff + PW'(1);
      end else begin
         comp_in = COMP_E2;
         kind    = cfg.e2_kind;
         last_in = 1'b1;
         pos_in  = '0;
      end
   end

   // non-Gaussian kinds
   always_comb begin
      case (kind)
         KIND_ETA1: small_in = 7'(b[0]) - 7'(b[1]);
         KIND_ETA3: small_in = (7'(b[0]) + 7'(b[1]) + 7'(b[2]))
                             - (7'(b[3]) + 7'(b[4]) + 7'(b[5]));
         KIND_UNIF: small_in = 7'(mod7(b)) - 7'd3;
         default:   small_in = '0;
      endcase
   end

   // mirror: upper half reads directly, lower half reads the reflected entry
   assign rd_addr = b[7] ? b[6:0] : ~b[6:0];

   // table memory
   always_ff @(posedge clock) begin
      if (tbl_wr.we) tbl_mem[tbl_wr.addr] <= tbl_wr.data;
   end
   always_ff @(posedge clock) begin
      if (adv) rd_ff <= tbl_mem[rd_addr];
   end

   // position counter
   always_ff @(posedge clock) begin
      if (reset)       pos_ff <= '0;
      else if (accept) pos_ff <= pos_in;
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= accept;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         gauss1_ff <= (kind == KIND_GAUSS);
         neg1_ff   <= !b[7];
         small1_ff <= small_in;
         comp1_ff  <= comp_in;
         last1_ff  <= last_in;
      end
   end

   // stage 2: z * sigma
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         gauss2_ff <= gauss1_ff;
         neg2_ff   <= neg1_ff;
         small2_ff <= small1_ff;
         comp2_ff  <= comp1_ff;
         last2_ff  <= last1_ff;
         prod2_ff  <= 26'(rd_ff) * 26'(cfg.sigma);
      end
   end

   // clamp to 6 sigma, round half away from zero
   assign bound     = {(14'(cfg.sigma) << 2) + (14'(cfg.sigma) << 1), 12'b0};
   assign clamped   = (prod2_ff > bound) ? bound : prod2_ff;
   assign rnd       = 27'(clamped) + 27'h8_0000;
   assign gmag      = rnd[26:20];
   assign sample_in = gauss2_ff ? (neg2_ff ? -gmag : gmag) : small2_ff;

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_sample_ff <= sample_in;
         rsp_comp_ff   <= comp2_ff;
         rsp_last_ff   <= last2_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sample    = rsp_sample_ff;
   assign rsp_component = rsp_comp_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

FILE: rtl/lwe_noise_sampler.sv
// ----------------------------------------------------------------------------
// lwe_noise_sampler
// Noise sampler: one random byte in, one signed noise sample out.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: one random byte per transaction (req_valid / req_stall).
//  rsp channel: sample, component (0 r, 1 e1, 2 e2) and last, which marks
//  the e2 sample closing each round of r, e1 and e2 samples.
//  Registers on the APB-style port: r_kind, e1_kind, e2_kind, sigma_q8 and
//  vector_len at byte addresses 0, 4, 8, 12, 16; write only while idle.
//  rsp_valid rises once the accepted byte has passed stage 1, stage 2 and
//  the output register; one transaction per cycle sustained while the
//  receiver does not stall, since the table read, the sigma multiply and
//  the clamp each take one pipeline stage.
//  After reset the table builder fills the 128-entry inverse CDF memory,
//  running the multiply, divide, add and check states on each of about
//  11,800 grid steps (at most 16384), plus a write per entry; req_stall
//  stays high until it is done. Register writes are taken during that time.
//  When the receiver stalls, the output register holds its transaction and
//  the whole pipeline freezes, raising req_stall in the same cycle.
// ----------------------------------------------------------------------------
module lwe_noise_sampler #(
   parameter int MAX_LEN = lns_pkg::DEF_MAX_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_random_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [6:0] rsp_sample,
   output logic [1:0]        rsp_component,
   output logic              rsp_last,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import lns_pkg::*;

   cfg_type    cfg_ff;
   tbl_wr_type tbl_wr;
   logic       tbl_ready;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.r_kind     <= RST_R_KIND;
         cfg_ff.e1_kind    <= RST_E1_KIND;
         cfg_ff.e2_kind    <= RST_E2_KIND;
         cfg_ff.sigma      <= RST_SIGMA;
         cfg_ff.vector_len <= RST_LEN;
      end else if (wr_en) begin
         case (paddr[4:2])
            REG_R_KIND:     cfg_ff.r_kind     <= kind_type'(pwdata[1:0]);
            REG_E1_KIND:    cfg_ff.e1_kind    <= kind_type'(pwdata[1:0]);
            REG_E2_KIND:    cfg_ff.e2_kind    <= kind_type'(pwdata[1:0]);
            REG_SIGMA:      cfg_ff.sigma      <= pwdata[SIGMA_W-1:0];
            REG_VECTOR_LEN: cfg_ff.vector_len <= pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (paddr[4:2])
         REG_R_KIND:     prdata = 32'(cfg_ff.r_kind);
         REG_E1_KIND:    prdata = 32'(cfg_ff.e1_kind);
         REG_E2_KIND:    prdata = 32'(cfg_ff.e2_kind);
         REG_SIGMA:      prdata = 32'(cfg_ff.sigma);
         REG_VECTOR_LEN: prdata = 32'(cfg_ff.vector_len);
         default:        prdata = '0;
      endcase
   end

   lns_table_gen u_gen (
      .clock  (clock),
      .reset  (reset),
      .tbl_wr (tbl_wr),
      .done   (tbl_ready)
   );

   lns_sample_pipe #(
      .MAX_LEN (MAX_LEN)
   ) u_pipe (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .tbl_wr          (tbl_wr),
      .tbl_ready       (tbl_ready),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_random_byte (req_random_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_component   (rsp_component),
      .rsp_last        (rsp_last)
   );

   // no input taken while the table is being built
   a_no_accept_init: assert property (@(posedge clock) disable iff (reset)
      !tbl_ready |-> req_stall)
      else $error("input accepted before table was built");

   // last marks exactly the e2 sample
   a_last_e2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_component == COMP_E2)))
      else $error("last does not match component");

   // sample stays within six sigma of the widest setting
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample <= 7'sd48 && rsp_sample >= -7'sd48))
      else $error("sample out of range");

   // table is never written once the builder has finished
   a_tbl_frozen: assert property (@(posedge clock) disable iff (reset)
      tbl_ready |-> !tbl_wr.we)
      else $error("table write after build");

endmodule

FILE: verif/lwe_noise_sampler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lwe_noise_sampler_tb
// Self-checking bench for the noise sampler: random bytes go in, each sample
// is compared against a local model of the r / e1 / e2 walk, the four kinds
// and the Gaussian inverse CDF table, under random gaps and receiver stalls.
// ----------------------------------------------------------------------------
module lwe_noise_sampler_tb;
   import lns_pkg::*;

   typedef struct packed {
      logic [6:0] sample;
      logic [1:0] component;
      logic       last;
   } noise_txn_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_random_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [6:0] rsp_sample;
   logic [1:0]        rsp_component;
   logic              rsp_last;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [4:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   // model state
   int unsigned       icdf_mag [TBL_DEPTH];
   kind_type          m_kind [3];
   logic [10:0]       m_sigma;
   logic [10:0]       m_len;
   int unsigned       m_pos;
   noise_txn_type     samples_due [$];
   int                n_errors = 0;
   bit                quiet = 1'b0;
   int                stall_cnt = 0;

   lwe_noise_sampler u_top (.*);

   always #6 clock = ~clock;

   function automatic longint unsigned q32_mul(longint unsigned a, longint unsigned b);
      return (a * b + 64'h8000_0000) >> 32;
   endfunction

   // integrate the normal density on a 1/4096 grid to find each quantile
   function automatic void build_icdf();
      longint unsigned dens, area, d, t1, t2, t3, nxt, anext, tgt;
      int unsigned     k, i;
      dens = 64'd1713444047;
      area = 0;
      k = 0;
      i = 0;
      while (k < TBL_DEPTH && i < 16384) begin
         d = 256 * longint'(i) + 128;
         t1 = q32_mul(dens, d);
         t2 = q32_mul(t1, d);
         t3 = q32_mul(t2, d);
         nxt = dens - t1 + t2 / 2 - t3 / 6;
         anext = area + dens + nxt;
         while (k < TBL_DEPTH) begin
            tgt = (2 * longint'(k) + 1) << 36;
            if (anext < tgt) break;
            icdf_mag[k] = (tgt - area <= anext - tgt) ? i : i + 1;
            k++;
         end
         area = anext;
         dens = nxt;
         i++;
      end
      while (k < TBL_DEPTH) begin
         icdf_mag[k] = i;
         k++;
      end
   endfunction

   function automatic int gauss_value(logic [7:0] b);
      longint z, val, bound, mag, r;
      if (b >= 128) z = icdf_mag[b - 128];
      else z = -longint'(icdf_mag[127 - b]);
      val = z * longint'(m_sigma);
      bound = 6 * longint'(m_sigma) * 4096;
      if (val > bound) val = bound;
      if (val < -bound) val = -bound;
      mag = val < 0 ? -val : val;
      r = (mag + (64'd1 << 19)) >> 20;
      return val < 0 ? -int'(r) : int'(r);
   endfunction

   function automatic int noise_value(logic [7:0] b, kind_type k);
      case (k)
         KIND_ETA1: return int'(b[0]) - int'(b[1]);
         KIND_ETA3: return int'(b[0]) + b[1] + b[2] - (int'(b[3]) + b[4] + b[5]);
         KIND_GAUSS: return gauss_value(b);
         default: return int'(b % 8'd7) - 3;
      endcase
   endfunction

   // advance the component walk by one accepted byte
   function automatic void predict_sample(logic [7:0] b);
      int unsigned   n;
      int            s;
      noise_txn_type t;
      n = m_len;
      if (n < 1) n = 1;
      if (n > DEF_MAX_LEN) n = DEF_MAX_LEN;
      t.last = 1'b0;
      if (m_pos < n) begin
         t.component = COMP_R;
         s = noise_value(b, m_kind[0]);
         m_pos++;
      end else if (m_pos < 2 * n) begin
         t.component = COMP_E1;
         s = noise_value(b, m_kind[1]);
         m_pos++;
      end else begin
         t.component = COMP_E2;
         t.last = 1'b1;
         s = noise_value(b, m_kind[2]);
         m_pos = 0;
      end
      t.sample = s[6:0];
      samples_due = {samples_due, t};
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_R_KIND: m_kind[0] = kind_type'(val[1:0]);
         REG_E1_KIND: m_kind[1] = kind_type'(val[1:0]);
         REG_E2_KIND: m_kind[2] = kind_type'(val[1:0]);
         REG_SIGMA: m_sigma = val[10:0];
         REG_VECTOR_LEN: m_len = val[10:0];
         default: ;
      endcase
   endtask

   // one transaction on the request channel, with a random gap ahead of it
   task automatic send_byte(logic [7:0] b);
      int r, gap;
      r = $urandom_range(0, 99);
      gap = quiet ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_random_byte <= b;
      do @(posedge clock); while (req_stall);
      predict_sample(b);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (samples_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_all(kind_type kr, kind_type ke1, kind_type ke2,
                          logic [31:0] sig, logic [31:0] len);
      csr_write(REG_R_KIND, 32'(kr));
      csr_write(REG_E1_KIND, 32'(ke1));
      csr_write(REG_E2_KIND, 32'(ke2));
      csr_write(REG_SIGMA, sig);
      csr_write(REG_VECTOR_LEN, len);
   endtask

   // reset values, Gaussian extremes and the table midpoint
   task automatic test_reset_config();
      logic [7:0] pat [6] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'hFE};
      quiet = 1'b1;
      foreach (pat[i]) send_byte(pat[i]);
      quiet = 1'b0;
      drain();
   endtask

   // every kind on at least one component, sigma and length extremes
   task automatic test_kinds();
      set_all(KIND_ETA1, KIND_ETA3, KIND_GAUSS, 32'hFFFF_F800 | 32'd2047, 32'd0);
      send_byte(8'h03); send_byte(8'h3F); send_byte(8'hFF);
      send_byte(8'h00);
      drain();
      set_all(KIND_UNIF, KIND_GAUSS, KIND_ETA3, 32'd0, 32'hFFFF_F801);
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'h38);
      drain();
      // length above the maximum behaves as the maximum
      set_all(KIND_GAUSS, KIND_UNIF, KIND_ETA1, 32'd2047, 32'd2047);
      send_byte(8'h06); send_byte(8'h07); send_byte(8'hFC);
      drain();
      // a write past the register list changes nothing
      csr_write(3'd7, 32'hFFFF_FFFF);
      csr_write(3'd5, 32'h0);
      send_byte(8'h00); send_byte(8'hFF);
      drain();
   endtask

   // shrinking the length mid-round forces the e2 sample
   task automatic test_len_shrink();
      set_all(KIND_ETA3, KIND_ETA1, KIND_UNIF, 32'd256, 32'd1024);
      csr_write(REG_VECTOR_LEN, 32'd4);
      repeat (6) send_byte(8'($urandom_range(0, 255)));
      drain();
      csr_write(REG_VECTOR_LEN, 32'd2);
      send_byte(8'hAA); send_byte(8'h55);
      drain();
   endtask

   task automatic test_random();
      int sent, n, r;
      logic [31:0] len, sig;
      sent = 0;
      while (sent < 1050) begin
         r = $urandom_range(0, 19);
         len = (r == 0) ? 32'd0 : (r == 1) ? 32'd1024 : (r == 2) ? 32'd2047 :
               $urandom_range(1, 8);
         r = $urandom_range(0, 9);
         sig = (r == 0) ? 32'd0 : (r == 1) ? 32'd2047 : $urandom();
         set_all(kind_type'($urandom_range(0, 3)), kind_type'($urandom_range(0, 3)),
                 kind_type'($urandom_range(0, 3)), sig, len);
         quiet = ($urandom_range(0, 4) == 0);
         n = $urandom_range(20, 80);
         repeat (n) send_byte(8'($urandom_range(0, 255)));
         sent += n;
         quiet = 1'b0;
         drain();
      end
   endtask

   // receiver stall pattern: mostly short bursts, occasionally long ones
   always @(posedge clock) begin
      int r;
      if (stall_cnt > 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 20) stall_cnt <= $urandom_range(0, 2);
         else if (r < 23) stall_cnt <= $urandom_range(10, 40);
         rsp_stall <= (r < 23);
      end
   end

   // compare every accepted response transaction with the oldest prediction
   always @(posedge clock) begin
      noise_txn_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (samples_due.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected sample %0d comp %0d last %0b",
                                         rsp_sample, rsp_component, rsp_last);
         end else begin
            want = samples_due.pop_front();
            if (want != {rsp_sample, rsp_component, rsp_last}) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("sample mismatch: want %0d/%0d/%0b got %0d/%0d/%0b",
                           $signed(want.sample), want.component, want.last,
                           rsp_sample, rsp_component, rsp_last);
            end
         end
      end
   end

   initial begin
      build_icdf();
      m_kind[0] = RST_R_KIND;
      m_kind[1] = RST_E1_KIND;
      m_kind[2] = RST_E2_KIND;
      m_sigma = RST_SIGMA;
      m_len = RST_LEN;
      m_pos = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_config();
      test_kinds();
      test_len_shrink();
      test_random();
      if (n_errors == 0 && samples_due.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #10ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/lns_pkg.sv
rtl/lns_table_gen.sv
rtl/lns_sample_pipe.sv
rtl/lwe_noise_sampler.sv
verif/lwe_noise_sampler_tb.sv
